### sv/catmull_rom_spline_eval_core_macros.svh
// assertion macros for the spline evaluator
// no dependencies
`ifndef CATMULL_ROM_SPLINE_EVAL_CORE_MACROS_SVH
`define CATMULL_ROM_SPLINE_EVAL_CORE_MACROS_SVH
// property that holds in the cycle after a condition
`define CRS_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);
// property that holds whenever the condition holds
`define CRS_ASSERT_NOW(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);
`endif

### sv/crs_pkg.sv
// shared constants and types for the spline evaluator
// no dependencies
package crs_pkg;
  localparam int MaxPoints = 64;
  localparam int CoordBits = 24;
  localparam int TimeFracBits = 16;
  localparam int IdxBits = $clog2(MaxPoints);
  localparam int CountBits = IdxBits + 1;
  localparam int TimeBits = TimeFracBits + 1;
  localparam int HBits = TimeFracBits + 5;
  localparam int AccBits = CoordBits + HBits + 3;
  localparam int DigitBits = 4;
  localparam int StoreBits = 3 * CoordBits;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  localparam logic ACT_APPEND = 1'b0;
  localparam logic ACT_EVAL = 1'b1;
endpackage

### sv/crs_stream_if.sv
// valid/ready channel interfaces for the spline evaluator
// depends on crs_pkg
interface crs_in_if;
  import crs_pkg::*;
  logic valid;
  logic ready;
  logic action;
  logic signed [CoordBits-1:0] point_x;
  logic signed [CoordBits-1:0] point_y;
  logic signed [CoordBits-1:0] point_z;
  logic [TimeBits-1:0] eval_time;
  modport source (output valid, action, point_x, point_y, point_z, eval_time, input ready);
  modport sink (input valid, action, point_x, point_y, point_z, eval_time, output ready);
endinterface

interface crs_out_if;
  import crs_pkg::*;
  logic valid;
  logic ready;
  logic signed [CoordBits-1:0] curve_x;
  logic signed [CoordBits-1:0] curve_y;
  logic signed [CoordBits-1:0] curve_z;
  logic [1:0] status;
  logic [CountBits-1:0] stored_points;
  modport source (output valid, curve_x, curve_y, curve_z, status, stored_points, input ready);
  modport sink (input valid, curve_x, curve_y, curve_z, status, stored_points, output ready);
endinterface

### sv/crs_ram.sv
// generic single port ram with registered read
// no dependencies
module crs_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

### sv/catmull_rom_spline_eval_core.sv
// channel     dir  payload
// in          in   action, point_x/y/z, eval_time
// out         out  curve_x/y/z, status, stored_points
// append: a beat is accepted and then its result is presented.
// evaluate: uses the 4-bit digit-serial multiplier for t*scale, u*u and u2*u, then a
// basis step, then per tap a read address, a read wait and three point-by-basis
// products, then rounding of each axis, the result and a return to idle. an evaluate
// on an empty store goes straight to the result. reset clears the point count and the
// control, store contents stay undefined until written.
// a result waits in the output register; no new beat until it is taken.
module catmull_rom_spline_eval_core
  import crs_pkg::*;
(
  input logic clk,
  input logic rst_n,
  crs_in_if.sink   in_ch,
  crs_out_if.source out_ch
);
`include "catmull_rom_spline_eval_core_macros.svh"

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_SCALE = 10'b0000000010,
    S_U2    = 10'b0000000100,
    S_U3    = 10'b0000001000,
    S_BASIS = 10'b0000010000,
    S_RADDR = 10'b0000100000,
    S_RWAIT = 10'b0001000000,
    S_MUL   = 10'b0010000000,
    S_FIN   = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  localparam int MulBits = CoordBits > HBits ? CoordBits : HBits;
  localparam int Digits = (MulBits + DigitBits - 1) / DigitBits;
  localparam int DcBits = $clog2(Digits + 1);
  localparam int PBits = 2 * MulBits + 2;
  localparam logic [TimeBits-1:0] TOne = TimeBits'(1) << TimeFracBits;
  localparam logic [HBits-1:0] HalfOne = HBits'(1) << (TimeFracBits - 1);

  state_t state_r, state_nxt;
  logic [CountBits-1:0] count_r;
  logic [TimeBits-1:0] t_r;
  logic [TimeFracBits-1:0] u_r, u2_r, u3_r;
  logic [CountBits-1:0] seg_r;
  logic signed [HBits-1:0] h_r [4];
  logic [1:0] k_r;
  logic [1:0] ax_r;
  logic signed [AccBits-1:0] acc_r [3];
  logic signed [CoordBits-1:0] res_r [3];
  logic [1:0] status_r;

  // shared digit-serial multiplier: signed a times unsigned-digit b
  logic signed [PBits-1:0] ma_r, mp_r;
  logic [MulBits-1:0] mb_r;
  logic mneg_r;
  logic [DcBits-1:0] dc_r;
  logic mbusy_r;

  logic [StoreBits-1:0] rdata;
  function automatic logic signed [CoordBits-1:0] rd_coord(input logic [1:0] a);
    case (a)
      2'd0: rd_coord = rdata[CoordBits-1:0];
      2'd1: rd_coord = rdata[2*CoordBits-1:CoordBits];
      default: rd_coord = rdata[3*CoordBits-1:2*CoordBits];
    endcase
  endfunction

  logic mstart;
  logic signed [PBits-1:0] mstart_a;
  logic signed [MulBits:0] mstart_b;
  always_comb begin
    mstart = 1'b0;
    mstart_a = '0;
    mstart_b = '0;
    case (state_r)
      S_SCALE: begin
        mstart = !mbusy_r && dc_r == '0;
        mstart_a = PBits'(t_r);
        mstart_b = (MulBits+1)'(count_r - 1'b1);
      end
      S_U2: begin
        mstart = !mbusy_r && dc_r == '0;
        mstart_a = PBits'(u_r);
        mstart_b = (MulBits+1)'(u_r);
      end
      S_U3: begin
        mstart = !mbusy_r && dc_r == '0;
        mstart_a = PBits'(u2_r);
        mstart_b = (MulBits+1)'(u_r);
      end
      S_MUL: begin
        mstart = !mbusy_r && dc_r == '0;
        mstart_a = PBits'(rd_coord(ax_r));
        mstart_b = (MulBits+1)'(h_r[k_r]);
      end
      default: ;
    endcase
  end

  logic mdone;
  assign mdone = mbusy_r && dc_r == DcBits'(Digits);
  logic signed [PBits-1:0] mres;
  assign mres = mneg_r ? -mp_r : mp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mbusy_r <= 1'b0;
      dc_r <= '0;
    end else if (mstart) begin
      mbusy_r <= 1'b1;
      dc_r <= '0;
      ma_r <= mstart_a;
      mneg_r <= mstart_b[MulBits];
      mb_r <= mstart_b[MulBits] ? MulBits'(-mstart_b) : mstart_b[MulBits-1:0];
      mp_r <= '0;
    end else if (mdone) begin
      mbusy_r <= 1'b0;
      dc_r <= '0;
    end else if (mbusy_r) begin
      mp_r <= mp_r + ((ma_r * $signed({1'b0, mb_r[DigitBits-1:0]}))
              <<< (DigitBits * dc_r));
      mb_r <= mb_r >> DigitBits;
      dc_r <= dc_r + 1'b1;
    end
  end

  // store
  logic we;
  logic [IdxBits-1:0] addr;
  logic [IdxBits-1:0] raddr;
  crs_ram #(.Width(StoreBits), .Depth(MaxPoints)) u_store (
    .clk(clk), .we(we), .addr(addr),
    .wdata({in_ch.point_z, in_ch.point_y, in_ch.point_x}), .rdata(rdata)
  );

  logic accept;
  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = state_r == S_IDLE;
  logic full;
  assign full = count_r == CountBits'(MaxPoints);
  assign we = accept && in_ch.action == ACT_APPEND && !full;
  assign addr = we ? count_r[IdxBits-1:0] : raddr;

  // clamped index for tap k
  logic signed [CountBits+1:0] idx_s;
  always_comb begin
    idx_s = $signed({2'b0, seg_r}) + $signed((CountBits+2)'(k_r))
            - $signed((CountBits+2)'(1));
    if (idx_s < 0) raddr = '0;
    else if (idx_s > $signed({2'b0, count_r}) - $signed((CountBits+2)'(1)))
      raddr = IdxBits'(count_r - 1'b1);
    else raddr = idx_s[IdxBits-1:0];
  end

  // basis from u, u2, u3
  logic signed [HBits-1:0] su, su2, su3;
  assign su = HBits'(u_r);
  assign su2 = HBits'(u2_r);
  assign su3 = HBits'(u3_r);

  logic signed [AccBits:0] rnd;
  logic signed [AccBits-TimeFracBits:0] shf;
  logic signed [CoordBits-1:0] sat;
  always_comb begin
    rnd = (AccBits+1)'(acc_r[ax_r]) + (AccBits+1)'(1 <<< TimeFracBits);
    shf = $signed({rnd[AccBits], rnd[AccBits:TimeFracBits+1]});
    if (shf > $signed((AccBits-TimeFracBits+1)'({1'b0, {(CoordBits-1){1'b1}}})))
      sat = {1'b0, {(CoordBits-1){1'b1}}};
    else if (shf < -$signed((AccBits-TimeFracBits+1)'(1 <<< (CoordBits-1))))
      sat = {1'b1, {(CoordBits-1){1'b0}}};
    else sat = shf[CoordBits-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (accept) begin
        if (in_ch.action == ACT_EVAL && count_r != '0) state_nxt = S_SCALE;
        else state_nxt = S_OUT;
      end
      S_SCALE: if (mdone) state_nxt = S_U2;
      S_U2:    if (mdone) state_nxt = S_U3;
      S_U3:    if (mdone) state_nxt = S_BASIS;
      S_BASIS: state_nxt = S_RADDR;
      S_RADDR: state_nxt = S_RWAIT;
      S_RWAIT: state_nxt = S_MUL;
      S_MUL: if (mdone) begin
        if (ax_r == 2'd2) state_nxt = (k_r == 2'd3) ? S_FIN : S_RADDR;
      end
      S_FIN: if (ax_r == 2'd2) state_nxt = S_OUT;
      S_OUT: if (out_ch.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (we) count_r <= count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: if (accept) begin
        t_r <= in_ch.eval_time > TOne ? TOne : in_ch.eval_time;
        k_r <= '0;
        ax_r <= '0;
        for (int i = 0; i < 3; i++) begin
          res_r[i] <= '0;
          acc_r[i] <= '0;
        end
        if (in_ch.action == ACT_APPEND) status_r <= full ? ST_FULL : ST_OK;
        else status_r <= count_r == '0 ? ST_EMPTY : ST_OK;
      end
      S_SCALE: if (mdone) begin
        seg_r <= CountBits'(mres >>> TimeFracBits);
        u_r <= mres[TimeFracBits-1:0];
      end
      S_U2: if (mdone) u2_r <= TimeFracBits'((mres + PBits'(HalfOne)) >>> TimeFracBits);
      S_U3: if (mdone) u3_r <= TimeFracBits'((mres + PBits'(HalfOne)) >>> TimeFracBits);
      S_BASIS: begin
        h_r[0] <= -su3 + (su2 <<< 1) - su;
        h_r[1] <= (su3 <<< 1) + su3 - (su2 <<< 2) - su2 + (HBits'(TOne) <<< 1);
        h_r[2] <= -(su3 <<< 1) - su3 + (su2 <<< 2) + su;
        h_r[3] <= su3 - su2;
      end
      S_MUL: if (mdone) begin
        acc_r[ax_r] <= acc_r[ax_r] + AccBits'(mres);
        if (ax_r == 2'd2) begin
          ax_r <= '0;
          k_r <= k_r + 1'b1;
        end else ax_r <= ax_r + 1'b1;
      end
      S_FIN: begin
        res_r[ax_r] <= sat;
        ax_r <= ax_r == 2'd2 ? 2'd0 : ax_r + 1'b1;
      end
      default: ;
    endcase
  end

  assign out_ch.valid = state_r == S_OUT;
  assign out_ch.curve_x = res_r[0];
  assign out_ch.curve_y = res_r[1];
  assign out_ch.curve_z = res_r[2];
  assign out_ch.status = status_r;
  assign out_ch.stored_points = count_r;

  `CRS_ASSERT_NOW(a_count_max, 1'b1, count_r <= CountBits'(MaxPoints), "count overflow")
  `CRS_ASSERT_NEXT(a_full_keeps, accept && full, count_r == $past(count_r), "full store grew")
  `CRS_ASSERT_NOW(a_ready_out, out_ch.valid, !in_ch.ready, "ready while result pending")
  `CRS_ASSERT_NOW(a_mul_idle, state_r == S_IDLE, !mbusy_r, "multiplier busy in idle")
endmodule

### verif/tb_catmull_rom_spline_eval_core.sv
// self-checking testbench for the catmull-rom spline evaluator core
// depends on crs_pkg and the crs_in_if / crs_out_if channel interfaces
// predicts every result beat in-bench and compares each one field by field
module tb_catmull_rom_spline_eval_core;
  timeunit 1ns;
  timeprecision 1ps;
  import crs_pkg::*;

  localparam int TOne = 1 << TimeFracBits;
  localparam int CoordMax = (1 << (CoordBits - 1)) - 1;
  localparam int CoordMin = -(1 << (CoordBits - 1));
  localparam int WatchLimit = 4000;
  localparam int TailCycles = 400;

  typedef struct {
    logic action;
    logic signed [CoordBits-1:0] px;
    logic signed [CoordBits-1:0] py;
    logic signed [CoordBits-1:0] pz;
    logic [TimeBits-1:0] t;
    bit drain;
  } spline_req_t;

  typedef struct {
    logic signed [CoordBits-1:0] cx;
    logic signed [CoordBits-1:0] cy;
    logic signed [CoordBits-1:0] cz;
    status_t status;
    logic [CountBits-1:0] count;
  } curve_pt_t;

  logic clk;
  logic rst_n;
  crs_in_if in_ch();
  crs_out_if out_ch();

  catmull_rom_spline_eval_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  spline_req_t pending_reqs[$];
  curve_pt_t expected_pts[$];
  logic signed [CoordBits-1:0] way_x[MaxPoints];
  logic signed [CoordBits-1:0] way_y[MaxPoints];
  logic signed [CoordBits-1:0] way_z[MaxPoints];
  int way_count;
  int sent_cnt, taken_cnt, result_cnt, errors, idle_cycles;
  int n_eval, n_append, n_full, n_empty;
  int in_gap, out_gap;
  bit calm;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch at result %0d: %s got %0d expected %0d", result_cnt, what, got, want);
    errors++;
  endtask

  function automatic logic signed [CoordBits-1:0] blend_axis(
      input longint p0, input longint p1, input longint p2, input longint p3,
      input longint h0, input longint h1, input longint h2, input longint h3);
    longint acc, r;
    acc = p0 * h0 + p1 * h1 + p2 * h2 + p3 * h3;
    r = (acc + TOne) >>> (TimeFracBits + 1);
    if (r > CoordMax) r = CoordMax;
    if (r < CoordMin) r = CoordMin;
    return r[CoordBits-1:0];
  endfunction

  function automatic int clamp_idx(input longint i);
    if (i < 0) return 0;
    if (i > way_count - 1) return way_count - 1;
    return int'(i);
  endfunction

  // updates the waypoint store and returns the expected curve point
  function automatic curve_pt_t spline_predict(input spline_req_t rq);
    curve_pt_t e;
    longint t, scaled, seg, u, u2, u3;
    longint h[4];
    int ix[4];
    e = '{cx: '0, cy: '0, cz: '0, status: ST_OK, count: '0};
    if (rq.action == ACT_APPEND) begin
      if (way_count >= MaxPoints) begin
        e.status = ST_FULL;
      end else begin
        way_x[way_count] = rq.px;
        way_y[way_count] = rq.py;
        way_z[way_count] = rq.pz;
        way_count++;
      end
    end else if (way_count == 0) begin
      e.status = ST_EMPTY;
    end else begin
      t = rq.t;
      if (t > TOne) t = TOne;
      scaled = t * (way_count - 1);
      seg = scaled >>> TimeFracBits;
      u = scaled & (TOne - 1);
      u2 = (u * u + TOne / 2) >>> TimeFracBits;
      u3 = (u2 * u + TOne / 2) >>> TimeFracBits;
      h[0] = -u3 + 2 * u2 - u;
      h[1] = 3 * u3 - 5 * u2 + 2 * TOne;
      h[2] = -3 * u3 + 4 * u2 + u;
      h[3] = u3 - u2;
      for (int k = 0; k < 4; k++) ix[k] = clamp_idx(seg - 1 + k);
      e.cx = blend_axis(way_x[ix[0]], way_x[ix[1]], way_x[ix[2]], way_x[ix[3]],
                        h[0], h[1], h[2], h[3]);
      e.cy = blend_axis(way_y[ix[0]], way_y[ix[1]], way_y[ix[2]], way_y[ix[3]],
                        h[0], h[1], h[2], h[3]);
      e.cz = blend_axis(way_z[ix[0]], way_z[ix[1]], way_z[ix[2]], way_z[ix[3]],
                        h[0], h[1], h[2], h[3]);
    end
    e.count = way_count[CountBits-1:0];
    return e;
  endfunction

  function automatic logic signed [CoordBits-1:0] pick_coord();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return CoordBits'(CoordMax);
    if (sel == 1) return CoordBits'(CoordMin);
    if (sel < 5) return $signed(CoordBits'($urandom_range(0, 4095))) - $signed(CoordBits'(2048));
    return CoordBits'($urandom());
  endfunction

  task automatic push_append(input logic signed [CoordBits-1:0] x,
                             input logic signed [CoordBits-1:0] y,
                             input logic signed [CoordBits-1:0] z);
    spline_req_t rq;
    rq = '{action: ACT_APPEND, px: x, py: y, pz: z,
           t: TimeBits'($urandom()), drain: 1'b0};
    pending_reqs = {pending_reqs, rq};
  endtask

  task automatic push_eval(input logic [TimeBits-1:0] t, input bit drain);
    spline_req_t rq;
    rq = '{action: ACT_EVAL, px: CoordBits'($urandom()), py: CoordBits'($urandom()),
           pz: CoordBits'($urandom()), t: t, drain: drain};
    pending_reqs = {pending_reqs, rq};
  endtask

  // driver: new input beat presented at the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || taken_cnt == sent_cnt) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (pending_reqs.size() == 0 ||
                   (pending_reqs[0].drain && expected_pts.size() != 0)) begin
        in_ch.valid <= 1'b0;
      end else begin
        spline_req_t rq;
        rq = pending_reqs.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.action <= rq.action;
        in_ch.point_x <= rq.px;
        in_ch.point_y <= rq.py;
        in_ch.point_z <= rq.pz;
        in_ch.eval_time <= rq.t;
        sent_cnt <= sent_cnt + 1;
        if (!calm && $urandom_range(0, 5) == 0) in_gap <= $urandom_range(1, 18);
      end
    end
    calm <= pending_reqs.size() < 80;
    if (!rst_n || calm) begin
      out_ch.ready <= 1'b1;
    end else if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if ($urandom_range(0, 6) == 0) out_gap <= $urandom_range(1, 18);
    end
  end

  // monitor: both channels sampled at the rising edge
  always @(posedge clk) begin
    bit moved;
    moved = 1'b0;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        spline_req_t rq;
        curve_pt_t e;
        rq = '{action: in_ch.action, px: in_ch.point_x, py: in_ch.point_y,
               pz: in_ch.point_z, t: in_ch.eval_time, drain: 1'b0};
        e = spline_predict(rq);
        expected_pts = {expected_pts, e};
        taken_cnt <= taken_cnt + 1;
        moved = 1'b1;
        if (rq.action == ACT_EVAL) n_eval++; else n_append++;
        if (e.status == ST_FULL) n_full++;
        if (e.status == ST_EMPTY) n_empty++;
      end
      if (out_ch.valid && out_ch.ready) begin
        moved = 1'b1;
        if (expected_pts.size() == 0) begin
          $display("unexpected result beat %0d", result_cnt);
          errors++;
        end else begin
          curve_pt_t e;
          e = expected_pts.pop_front();
          if (out_ch.curve_x !== e.cx) report("curve_x", out_ch.curve_x, e.cx);
          if (out_ch.curve_y !== e.cy) report("curve_y", out_ch.curve_y, e.cy);
          if (out_ch.curve_z !== e.cz) report("curve_z", out_ch.curve_z, e.cz);
          if (out_ch.status !== e.status) report("status", out_ch.status, e.status);
          if (out_ch.stored_points !== e.count)
            report("stored_points", out_ch.stored_points, e.count);
        end
        result_cnt++;
      end
      idle_cycles <= moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
        $display("watchdog: no beat for %0d cycles", WatchLimit);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    int gen_count;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_APPEND;
    in_ch.point_x = '0;
    in_ch.point_y = '0;
    in_ch.point_z = '0;
    in_ch.eval_time = '0;
    out_ch.ready = 1'b0;
    way_count = 0;
    sent_cnt = 0; taken_cnt = 0; result_cnt = 0; errors = 0; idle_cycles = 0;
    n_eval = 0; n_append = 0; n_full = 0; n_empty = 0;
    in_gap = 0; out_gap = 0; calm = 1'b0;

    // directed: empty store, single point, extremes, saturating time
    push_eval('0, 1'b0);
    push_eval(TimeBits'(131071), 1'b0);
    push_append(CoordBits'(CoordMax), CoordBits'(CoordMin), '0);
    push_eval('0, 1'b0);
    push_eval(TimeBits'(TOne), 1'b0);
    push_eval(TimeBits'(131071), 1'b0);
    push_append(CoordBits'(CoordMin), CoordBits'(CoordMax), '1);
    push_eval(TimeBits'(TOne / 2), 1'b0);
    push_append(CoordBits'(CoordMax), CoordBits'(CoordMax), CoordBits'(CoordMin));
    push_append(CoordBits'(CoordMin), CoordBits'(CoordMin), CoordBits'(CoordMax));
    push_eval(TimeBits'(1), 1'b0);
    push_eval(TimeBits'(TOne - 1), 1'b0);
    push_eval(TimeBits'(21845), 1'b0);
    push_eval(TimeBits'(TOne / 3 + TOne / 2), 1'b0);
    push_append(CoordBits'(256), CoordBits'(-256), CoordBits'(1));
    push_eval(TimeBits'(TOne + 1), 1'b1);
    gen_count = 5;

    // random: fill the store with evals mixed in, then mostly evals
    for (int i = 0; i < 690; i++) begin
      bit drain;
      drain = (i == 300);
      if (gen_count < MaxPoints && $urandom_range(0, 9) < 7) begin
        push_append(pick_coord(), pick_coord(), pick_coord());
        gen_count++;
      end else if (gen_count >= MaxPoints && $urandom_range(0, 9) == 0) begin
        push_append(pick_coord(), pick_coord(), pick_coord());
      end else begin
        push_eval($urandom_range(0, 2) == 0 ? TimeBits'($urandom())
                                           : TimeBits'($urandom_range(0, TOne)), drain);
      end
    end

    repeat (7) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    wait (pending_reqs.size() == 0 && taken_cnt == sent_cnt && !in_ch.valid);
    wait (expected_pts.size() == 0);
    repeat (TailCycles) @(posedge clk);
    $display("covered %0d appends (%0d on a full store) and %0d evaluations (%0d on empty)",
             n_append, n_full, n_eval, n_empty);
    $display("%0d result beats checked, %0d mismatches", result_cnt, errors);
    if (errors == 0 && expected_pts.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
